### rtl/samdc_pkg.sv
// package: shared types, constants and tables for the carrier-tracking dc removal block
package samdc_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CNT_W         = $clog2(CORDIC_STAGES);
    localparam int CW            = 34;   // cordic datapath width
    localparam int AW            = 36;   // multiplier operand a
    localparam int BW            = 33;   // multiplier operand b
    localparam int PW            = AW + BW;

    localparam logic [29:0] INV_GAIN   = 30'd652032874;
    localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
    localparam logic [31:0] QTR_TURN   = 32'h4000_0000;

    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [2:0] REG_FREQ_LOW   = 3'd2;
    localparam logic [2:0] REG_FREQ_HIGH  = 3'd3;
    localparam logic [2:0] REG_DC_POLE    = 3'd4;

    localparam logic [23:0] PROP_GAIN_RST  = 24'd310535;
    localparam logic [23:0] INTEG_GAIN_RST = 24'd2874;
    localparam logic [31:0] FREQ_LOW_RST   = 32'hFAAA_AAAB;
    localparam logic [30:0] FREQ_HIGH_RST  = 31'd89478485;
    localparam logic [15:0] DC_POLE_RST    = 16'd65529;

    typedef enum logic [3:0] {
        S_IDLE, S_ROT, S_GX, S_GY, S_VINIT, S_VEC, S_GM, S_ERR,
        S_DIFF, S_IG, S_PG, S_LOOP, S_DCI, S_DCQ, S_OUT
    } t_state;

    typedef struct packed {
        logic       vec;     // vectoring mode when set, rotation otherwise
        logic [4:0] shift;   // micro-rotation index
    } t_cordic_ctl;

    localparam logic [31:0] ATAN_TAB [24] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    function automatic logic [31:0] atan_of(input logic [4:0] idx);
        logic [31:0] v;
        v = '0;
        if (idx < 5'd24) begin
            v = ATAN_TAB[idx];
        end
        return v;
    endfunction

endpackage

### rtl/sam_pll_carrier_dc_removal.sv
// top level: carrier-tracking pll with per-channel dc removal, one shared cordic and multiplier
//
// usage notes
// - input channel: i_valid / o_ready carry one complex sample (i_in_i, i_in_q) plus the
//   i_block_end marker per transaction
// - output channel: o_valid / i_ready carry one result transaction per input transaction,
//   o_out_i / o_out_q are the dc-removed, carrier-locked samples, o_block_end_out the marker
// - config: i_cfg_we writes i_cfg_data into register i_cfg_idx; write only while idle, which
//   the block does not enforce; 0 prop gain, 1 integ gain, 2/3 freq low/high limit, 4 dc pole
// - each sample walks a small sequencer: CORDIC_STAGES rotation steps, two gain-compensation
//   multiplies, CORDIC_STAGES vectoring steps, then magnitude, error, loop and two dc filter
//   multiplies on a single shared multiplier
// - o_ready is high only in idle, so one sample is in flight at a time; a new sample is taken
//   only after the shared cordic step unit and the multiplier have finished the last one
// - a stalled receiver holds the result in the output register; one more sample is taken and
//   finished, then the sequencer waits in its hand-off state until the register frees
// - reset (i_rst_n low, synchronous) clears oscillator phase, frequency, both dc accumulators,
//   loads the default register values and returns the sequencer to idle
module sam_pll_carrier_dc_removal (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_in_i,
    input  logic signed [15:0] i_in_q,
    input  logic               i_block_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [17:0] o_out_i,
    output logic signed [17:0] o_out_q,
    output logic               o_block_end_out
);
    localparam int CW = samdc_pkg::CW;
    localparam int AW = samdc_pkg::AW;
    localparam int BW = samdc_pkg::BW;
    localparam int PW = samdc_pkg::PW;
    localparam int CNT_W = samdc_pkg::CNT_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(samdc_pkg::CORDIC_STAGES - 1);

    // configuration registers
    logic [23:0] r_prop, r_integ;
    logic [31:0] r_low;
    logic [30:0] r_high;
    logic [15:0] r_pole;

    // loop and filter state
    logic [31:0]        r_phase;
    logic signed [31:0] r_freq;
    logic signed [31:0] r_acc_i, r_acc_q;

    // sequencer and datapath
    samdc_pkg::t_state     r_state, n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic signed [CW-1:0]  r_x, r_y, r_z;
    logic signed [CW-1:0]  r_gx, r_gy;
    logic signed [34:0]    r_diff;
    logic signed [PW-1:0]  r_prod;
    logic                  r_blk;
    logic signed [17:0]    r_di, r_dq;
    logic                  r_valid;
    logic signed [17:0]    r_out_i, r_out_q;
    logic                  r_blk_out;

    logic signed [AW-1:0]  m_a;
    logic signed [BW-1:0]  m_b;

    samdc_pkg::t_cordic_ctl c_ctl;
    logic signed [CW-1:0]   c_x, c_y, c_z;

    samdc_cordic u_cordic (
        .i_ctl (c_ctl),
        .i_x   (r_x),
        .i_y   (r_y),
        .i_z   (r_z),
        .o_x   (c_x),
        .o_y   (c_y),
        .o_z   (c_z)
    );

    // combinational views of the registered product
    logic signed [PW-1:0] prod_s30, prod_s24, neg_s29, dc_nw;
    logic signed [CW-1:0] gy_now;
    logic signed [34:0]   f_sum;
    logic signed [34:0]   f_clamp;
    logic signed [34:0]   lim_lo, lim_hi;
    logic signed [19:0]   xi_rnd, yi_rnd;
    logic signed [31:0]   acc_sat;
    logic signed [32:0]   dc_step;
    logic signed [17:0]   dc_out;
    logic signed [31:0]   acc_old;
    logic signed [19:0]   x_in;
    logic                 pre_rot;
    logic signed [CW-1:0] sx0, sy0;
    logic                 out_load;

    always_comb begin
        prod_s30 = r_prod >>> 30;
        prod_s24 = r_prod >>> 24;
        neg_s29  = (-r_prod) >>> 29;
        gy_now   = CW'(prod_s30);
        lim_lo   = 35'(signed'(r_low));
        lim_hi   = $signed({4'b0000, r_high});
        f_sum    = 35'(r_freq) + 35'(prod_s24);
        f_clamp  = f_sum;
        if (f_clamp < lim_lo) begin
            f_clamp = lim_lo;
        end
        if (f_clamp > lim_hi) begin
            f_clamp = lim_hi;
        end
        xi_rnd   = 20'((r_gx + CW'(8192)) >>> 14);
        yi_rnd   = 20'((r_gy + CW'(8192)) >>> 14);
        acc_old  = (r_state == samdc_pkg::S_DCI) ? r_acc_i : r_acc_q;
        x_in     = (r_state == samdc_pkg::S_DCI) ? xi_rnd : yi_rnd;
        dc_nw    = ((r_prod + PW'(32768)) >>> 16) + PW'(x_in);
        if (dc_nw > PW'(32'sh7FFF_FFFF)) begin
            acc_sat = 32'sh7FFF_FFFF;
        end else if (dc_nw < -PW'(33'sh0_8000_0000)) begin
            acc_sat = 32'sh8000_0000;
        end else begin
            acc_sat = 32'(dc_nw);
        end
        dc_step  = 33'(acc_sat) - 33'(acc_old);
        if (dc_step > 33'sd131071) begin
            dc_out = 18'sd131071;
        end else if (dc_step < -33'sd131072) begin
            dc_out = -18'sd131072;
        end else begin
            dc_out = 18'(dc_step);
        end
        // phase beyond a quarter turn either way: pre-rotate by a half turn
        pre_rot  = ($signed(r_phase) > $signed(samdc_pkg::QTR_TURN)) ||
                   ($signed(r_phase) < -$signed(samdc_pkg::QTR_TURN));
        sx0      = $signed({{(CW-30){i_in_i[15]}}, i_in_i, 14'b0});
        sy0      = $signed({{(CW-30){i_in_q[15]}}, i_in_q, 14'b0});
        // hand the finished sample to the output register once it is free
        out_load = (r_state == samdc_pkg::S_OUT) && (!r_valid || i_ready);
    end

    // shared multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            samdc_pkg::S_GX: begin
                m_a = AW'(r_x);
                m_b = $signed({3'b000, samdc_pkg::INV_GAIN});
            end
            samdc_pkg::S_GY: begin
                m_a = AW'(r_y);
                m_b = $signed({3'b000, samdc_pkg::INV_GAIN});
            end
            samdc_pkg::S_GM: begin
                m_a = AW'(r_x);
                m_b = $signed({3'b000, samdc_pkg::INV_GAIN});
            end
            samdc_pkg::S_ERR: begin
                m_a = AW'(prod_s30);
                m_b = BW'($signed(r_z[31:0]));
            end
            samdc_pkg::S_IG: begin
                m_a = AW'(r_diff);
                m_b = $signed({9'b0, r_integ});
            end
            samdc_pkg::S_PG: begin
                m_a = AW'(r_diff);
                m_b = $signed({9'b0, r_prop});
            end
            samdc_pkg::S_LOOP: begin
                m_a = AW'(r_acc_i);
                m_b = $signed({17'b0, r_pole});
            end
            samdc_pkg::S_DCI: begin
                m_a = AW'(r_acc_q);
                m_b = $signed({17'b0, r_pole});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    always_comb begin
        c_ctl.vec   = (r_state == samdc_pkg::S_VEC);
        c_ctl.shift = 5'(r_cnt);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            samdc_pkg::S_IDLE:  if (i_valid) n_state = samdc_pkg::S_ROT;
            samdc_pkg::S_ROT:   if (r_cnt == CNT_LAST) n_state = samdc_pkg::S_GX;
            samdc_pkg::S_GX:    n_state = samdc_pkg::S_GY;
            samdc_pkg::S_GY:    n_state = samdc_pkg::S_VINIT;
            samdc_pkg::S_VINIT: n_state = samdc_pkg::S_VEC;
            samdc_pkg::S_VEC:   if (r_cnt == CNT_LAST) n_state = samdc_pkg::S_GM;
            samdc_pkg::S_GM:    n_state = samdc_pkg::S_ERR;
            samdc_pkg::S_ERR:   n_state = samdc_pkg::S_DIFF;
            samdc_pkg::S_DIFF:  n_state = samdc_pkg::S_IG;
            samdc_pkg::S_IG:    n_state = samdc_pkg::S_PG;
            samdc_pkg::S_PG:    n_state = samdc_pkg::S_LOOP;
            samdc_pkg::S_LOOP:  n_state = samdc_pkg::S_DCI;
            samdc_pkg::S_DCI:   n_state = samdc_pkg::S_DCQ;
            samdc_pkg::S_DCQ:   n_state = samdc_pkg::S_OUT;
            samdc_pkg::S_OUT:   if (out_load) n_state = samdc_pkg::S_IDLE;
            default:            n_state = samdc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= samdc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop  <= samdc_pkg::PROP_GAIN_RST;
            r_integ <= samdc_pkg::INTEG_GAIN_RST;
            r_low   <= samdc_pkg::FREQ_LOW_RST;
            r_high  <= samdc_pkg::FREQ_HIGH_RST;
            r_pole  <= samdc_pkg::DC_POLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                samdc_pkg::REG_PROP_GAIN:  r_prop  <= i_cfg_data[23:0];
                samdc_pkg::REG_INTEG_GAIN: r_integ <= i_cfg_data[23:0];
                samdc_pkg::REG_FREQ_LOW:   r_low   <= i_cfg_data;
                samdc_pkg::REG_FREQ_HIGH:  r_high  <= i_cfg_data[30:0];
                samdc_pkg::REG_DC_POLE:    r_pole  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // loop state, accumulators and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_freq  <= '0;
            r_acc_i <= '0;
            r_acc_q <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_state == samdc_pkg::S_PG) begin
                r_freq <= 32'(f_clamp);
            end
            if (r_state == samdc_pkg::S_LOOP) begin
                // r_freq already holds the clamped frequency
                r_phase <= r_phase + 32'(r_freq) + 32'(prod_s24);
            end
            if (r_state == samdc_pkg::S_DCI) begin
                r_acc_i <= acc_sat;
            end
            if (r_state == samdc_pkg::S_DCQ) begin
                r_acc_q <= acc_sat;
            end
            if (out_load) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        unique case (r_state)
            samdc_pkg::S_IDLE: begin
                r_cnt <= '0;
                r_blk <= i_block_end;
                if (pre_rot) begin
                    r_x <= -sx0;
                    r_y <= -sy0;
                    r_z <= CW'($signed(r_phase + samdc_pkg::HALF_TURN));
                end else begin
                    r_x <= sx0;
                    r_y <= sy0;
                    r_z <= CW'($signed(r_phase));
                end
            end
            samdc_pkg::S_ROT, samdc_pkg::S_VEC: begin
                r_x   <= c_x;
                r_y   <= c_y;
                r_z   <= c_z;
                r_cnt <= r_cnt + CNT_W'(1);
            end
            samdc_pkg::S_GY: begin
                r_gx <= CW'(prod_s30);
            end
            samdc_pkg::S_VINIT: begin
                r_gy  <= gy_now;
                r_cnt <= '0;
                if (r_gx[CW-1]) begin
                    r_x <= -r_gx;
                    r_y <= -gy_now;
                    r_z <= $signed({2'b00, samdc_pkg::HALF_TURN});
                end else begin
                    r_x <= r_gx;
                    r_y <= gy_now;
                    r_z <= '0;
                end
            end
            samdc_pkg::S_DIFF: begin
                r_diff <= 35'(neg_s29);
            end
            samdc_pkg::S_DCI: begin
                r_di <= dc_out;
            end
            samdc_pkg::S_DCQ: begin
                r_dq <= dc_out;
            end
            default: ;
        endcase
        // output register, loaded only when empty or being emptied
        if (out_load) begin
            r_out_i   <= r_di;
            r_out_q   <= r_dq;
            r_blk_out <= r_blk;
        end
    end

    assign o_ready         = (r_state == samdc_pkg::S_IDLE);
    assign o_valid         = r_valid;
    assign o_out_i         = r_out_i;
    assign o_out_q         = r_out_q;
    assign o_block_end_out = r_blk_out;

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_i) && $stable(o_out_q)
                                   && $stable(o_block_end_out)))
        else $error("pending result changed before it was taken");
    a_stall_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == samdc_pkg::S_OUT) && o_valid && !i_ready) |=>
            (r_state == samdc_pkg::S_OUT))
        else $error("sequencer left hand-off while output was full");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == samdc_pkg::S_ROT))
        else $error("accepted transaction did not start rotation");
    a_freq_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == samdc_pkg::S_PG) |=> (r_freq <= $signed({1'b0, r_high})))
        else $error("loop frequency above high limit");
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == samdc_pkg::S_OUT) && (!o_valid || i_ready)) |=> o_valid)
        else $error("finished sample did not reach the output");
`endif

endmodule

### rtl/samdc_cordic.sv
// cordic micro-rotation: one shift-add step, rotation or vectoring mode
module samdc_cordic (
    input  samdc_pkg::t_cordic_ctl       i_ctl,
    input  logic signed [samdc_pkg::CW-1:0] i_x,
    input  logic signed [samdc_pkg::CW-1:0] i_y,
    input  logic signed [samdc_pkg::CW-1:0] i_z,
    output logic signed [samdc_pkg::CW-1:0] o_x,
    output logic signed [samdc_pkg::CW-1:0] o_y,
    output logic signed [samdc_pkg::CW-1:0] o_z
);
    logic signed [samdc_pkg::CW-1:0] xs, ys, at;
    logic                            pos;

    always_comb begin
        xs  = i_x >>> i_ctl.shift;
        ys  = i_y >>> i_ctl.shift;
        at  = $signed({2'b00, samdc_pkg::atan_of(i_ctl.shift)});
        // rotation drives z toward zero, vectoring drives y toward zero
        pos = i_ctl.vec ? i_y[samdc_pkg::CW-1] : ~i_z[samdc_pkg::CW-1];
        if (pos) begin
            o_x = i_x - ys;
            o_y = i_y + xs;
            o_z = i_z - at;
        end else begin
            o_x = i_x + ys;
            o_y = i_y - xs;
            o_z = i_z + at;
        end
    end
endmodule

### sim/sam_pll_carrier_dc_removal_tb.sv
// testbench for the carrier-tracking pll with dc removal, checked against an in-bench predictor
`timescale 1ns / 100ps

module sam_pll_carrier_dc_removal_tb;

    localparam int NSTG      = (samdc_pkg::CORDIC_STAGES < 1) ? 1 :
                               ((samdc_pkg::CORDIC_STAGES > 24) ? 24 :
                                samdc_pkg::CORDIC_STAGES);
    localparam int LATENCY   = 2 * samdc_pkg::CORDIC_STAGES + 12;
    localparam int N_RANDOM  = 400;
    localparam longint INV_G = 64'sd652032874;
    localparam logic [2:0] REG_NONE = 3'd7;   // no register at this index

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_in_i;
    logic signed [15:0] i_in_q;
    logic               i_block_end;
    logic               o_valid;
    logic               i_ready;
    logic signed [17:0] o_out_i;
    logic signed [17:0] o_out_q;
    logic               o_block_end_out;

    sam_pll_carrier_dc_removal dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_in_i(i_in_i), .i_in_q(i_in_q), .i_block_end(i_block_end),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_i(o_out_i), .o_out_q(o_out_q), .o_block_end_out(o_block_end_out)
    );

    // one output transaction
    typedef struct {
        logic signed [17:0] oi;
        logic signed [17:0] oq;
        logic               be;
    } t_sample_out;

    // predictor copy of the block registers and loop state
    logic [23:0]        m_prop_gain;
    logic [23:0]        m_integ_gain;
    logic signed [31:0] m_freq_low;
    logic [30:0]        m_freq_high;
    logic [15:0]        m_dc_pole;
    logic [31:0]        m_phase;
    logic signed [31:0] m_freq;
    logic signed [31:0] m_acc_i;
    logic signed [31:0] m_acc_q;

    t_sample_out locked_q[$];   // expected dc-removed samples, oldest first
    int          n_err;
    int          n_sent;
    int          n_recv;
    bit          hold_off;      // receiver long stall request
    bit          gaps_on;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // arithmetic shift right with floor semantics
    function automatic longint floor_shr(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void loop_reset();
        m_prop_gain  = samdc_pkg::PROP_GAIN_RST;
        m_integ_gain = samdc_pkg::INTEG_GAIN_RST;
        m_freq_low   = samdc_pkg::FREQ_LOW_RST;
        m_freq_high  = samdc_pkg::FREQ_HIGH_RST;
        m_dc_pole    = samdc_pkg::DC_POLE_RST;
        m_phase = '0; m_freq = '0; m_acc_i = '0; m_acc_q = '0;
    endfunction

    // one-pole dc blocker on a single rail, returns saturated 18 bit output
    function automatic logic signed [17:0] dc_block(inout logic signed [31:0] acc,
                                                    input longint x);
        longint prev;
        longint nxt;
        prev = acc;
        nxt  = floor_shr(longint'({1'b0, m_dc_pole}) * prev + 32768, 16) + x;
        nxt  = clip(nxt, -64'sd2147483648, 64'sd2147483647);
        acc  = nxt[31:0];
        return 18'(clip(nxt - prev, -131072, 131071));
    endfunction

    // carrier rotate, track and dc-remove one sample
    function automatic t_sample_out track_sample(input logic signed [15:0] si,
                                                 input logic signed [15:0] sq,
                                                 input logic be);
        t_sample_out r;
        longint x, y, z, dx, dy, vx, vy, mag, diff, fr, ph;
        logic [31:0] ang;
        logic [31:0] p2;
        x = longint'(si) * 16384;
        y = longint'(sq) * 16384;
        z = longint'($signed(m_phase));
        if (z > 64'sh40000000 || z < -64'sh40000000) begin
            x = -x; y = -y;
            p2 = m_phase + samdc_pkg::HALF_TURN;
            z = longint'($signed(p2));
        end
        for (int i = 0; i < NSTG; i++) begin
            dx = floor_shr(y, i); dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'({1'b0, samdc_pkg::ATAN_TAB[i]});
            end else begin
                x += dx; y -= dy; z += longint'({1'b0, samdc_pkg::ATAN_TAB[i]});
            end
        end
        x = floor_shr(x * INV_G, 30);
        y = floor_shr(y * INV_G, 30);
        vx = x; vy = y; ang = '0;
        if (vx < 0) begin
            vx = -vx; vy = -vy; ang = samdc_pkg::HALF_TURN;
        end
        for (int i = 0; i < NSTG; i++) begin
            dx = floor_shr(vy, i); dy = floor_shr(vx, i);
            if (vy >= 0) begin
                vx += dx; vy -= dy; ang += samdc_pkg::ATAN_TAB[i];
            end else begin
                vx -= dx; vy += dy; ang -= samdc_pkg::ATAN_TAB[i];
            end
        end
        mag  = floor_shr(vx * INV_G, 30);
        diff = floor_shr(-(mag * longint'($signed(ang))), 29);
        fr   = longint'(m_freq) + floor_shr(longint'({1'b0, m_integ_gain}) * diff, 24);
        if (fr < longint'(m_freq_low)) fr = m_freq_low;
        if (fr > longint'({1'b0, m_freq_high})) fr = {1'b0, m_freq_high};
        m_freq = fr[31:0];
        ph = longint'({1'b0, m_phase}) + fr
             + floor_shr(longint'({1'b0, m_prop_gain}) * diff, 24);
        m_phase = ph[31:0];
        r.oi = dc_block(m_acc_i, floor_shr(x + 8192, 14));
        r.oq = dc_block(m_acc_q, floor_shr(y + 8192, 14));
        r.be = be;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_recv);
        n_err++;
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            samdc_pkg::REG_PROP_GAIN:  m_prop_gain  = val[23:0];
            samdc_pkg::REG_INTEG_GAIN: m_integ_gain = val[23:0];
            samdc_pkg::REG_FREQ_LOW:   m_freq_low   = val;
            samdc_pkg::REG_FREQ_HIGH:  m_freq_high  = val[30:0];
            samdc_pkg::REG_DC_POLE:    m_dc_pole    = val[15:0];
            default: ;
        endcase
    endtask

    // wait until every expected result is back, then for the block latency
    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (locked_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // one input transaction; valid held until accepted
    task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq,
                               input logic be);
        int gap;
        gap = gaps_on ? $urandom_range(0, 17) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_in_i      <= si;
        i_in_q      <= sq;
        i_block_end <= be;
        locked_q.push_back(track_sample(si, sq, be));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_sent++;
    endtask

    // receiver: random stall before each transaction while gaps are on, plus a long hold-off when requested
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            stall = gaps_on ? $urandom_range(0, 17) : 0;
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_sample_out w;
        if (i_rst_n && o_valid && i_ready) begin
            if (locked_q.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                w = locked_q.pop_front();
                if (o_out_i !== w.oi) report_mismatch("out_i", o_out_i, w.oi);
                if (o_out_q !== w.oq) report_mismatch("out_q", o_out_q, w.oq);
                if (o_block_end_out !== w.be)
                    report_mismatch("block_end_out", o_block_end_out, w.be);
            end
            n_recv++;
        end
    end

    // directed rows: sample, marker, and a typed result where it is obvious
    typedef struct {
        logic signed [15:0] si;
        logic signed [15:0] sq;
        logic               be;
        bit                 typed;
        logic signed [17:0] oi;
        logic signed [17:0] oq;
    } t_row;

    t_row rows[12] = '{
        '{16'sd0,      16'sd0,      1'b0, 1'b1, 18'sd0, 18'sd0},   // zero input, no error
        '{16'sd0,      16'sd0,      1'b1, 1'b1, 18'sd0, 18'sd0},
        '{16'sd32767,  16'sd0,      1'b0, 1'b0, 18'sd0, 18'sd0},
        '{-16'sd32768, 16'sd0,      1'b1, 1'b0, 18'sd0, 18'sd0},   // half turn angle
        '{16'sd0,      16'sd32767,  1'b0, 1'b0, 18'sd0, 18'sd0},
        '{16'sd0,      -16'sd32768, 1'b0, 1'b0, 18'sd0, 18'sd0},
        '{-16'sd32768, -16'sd32768, 1'b1, 1'b0, 18'sd0, 18'sd0},
        '{16'sd32767,  16'sd32767,  1'b0, 1'b0, 18'sd0, 18'sd0},
        '{-16'sd32768, 16'sd32767,  1'b0, 1'b0, 18'sd0, 18'sd0},
        '{16'sd1,      -16'sd1,     1'b1, 1'b0, 18'sd0, 18'sd0},
        '{16'sh5555,   16'shAAAA,   1'b0, 1'b0, 18'sd0, 18'sd0},
        '{16'shAAAA,   16'sh5555,   1'b1, 1'b0, 18'sd0, 18'sd0}
    };

    initial begin
        t_sample_out r;
        int          n_cfg;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_in_i = '0; i_in_q = '0; i_block_end = 1'b0;
        n_err = 0; n_sent = 0; n_recv = 0; hold_off = 0; gaps_on = 0; n_cfg = 0;
        loop_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: typed results are checked against the predictor where given
        foreach (rows[k]) begin
            send_sample(rows[k].si, rows[k].sq, rows[k].be);
            if (rows[k].typed) begin
                r = locked_q[locked_q.size() - 1];
                if (r.oi !== rows[k].oi || r.oq !== rows[k].oq)
                    report_mismatch("predictor vs table row", k, -1);
            end
        end
        drain();

        // extreme settings: fast loop, full pole, widest limits, bad index ignored
        write_reg(samdc_pkg::REG_PROP_GAIN, 32'h00FF_FFFF);
        write_reg(samdc_pkg::REG_INTEG_GAIN, 32'h00FF_FFFF);
        write_reg(samdc_pkg::REG_FREQ_LOW, 32'h8000_0000);
        write_reg(samdc_pkg::REG_FREQ_HIGH, 32'h7FFF_FFFF);
        write_reg(samdc_pkg::REG_DC_POLE, 32'h0000_FFFF);
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        n_cfg += 6;
        for (int k = 0; k < 8; k++) send_sample(16'sd32767, -16'sd32768, k[0]);
        drain();
        write_reg(samdc_pkg::REG_PROP_GAIN, 32'd0);
        write_reg(samdc_pkg::REG_INTEG_GAIN, 32'd0);
        write_reg(samdc_pkg::REG_FREQ_LOW, 32'd0);
        write_reg(samdc_pkg::REG_FREQ_HIGH, 32'd0);
        write_reg(samdc_pkg::REG_DC_POLE, 32'd0);
        n_cfg += 5;
        for (int k = 0; k < 6; k++) send_sample(-16'sd32768, 16'sd32767, 1'b0);
        drain();

        // random part in phases with random settings, gaps on both sides
        gaps_on = 1;
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(samdc_pkg::REG_PROP_GAIN, $urandom_range(0, 24'hFFFFFF));
            write_reg(samdc_pkg::REG_INTEG_GAIN,
                      (ph == 0) ? 32'd2874 : $urandom_range(0, 24'hFFFFFF));
            write_reg(samdc_pkg::REG_FREQ_LOW,
                      (ph == 3) ? 32'h8000_0000 : -$urandom_range(0, 32'h7FFFFFFF));
            write_reg(samdc_pkg::REG_FREQ_HIGH,
                      (ph == 3) ? 32'h7FFF_FFFF : $urandom_range(0, 32'h7FFFFFFF));
            write_reg(samdc_pkg::REG_DC_POLE,
                      (ph == 2) ? 32'hFFFF : $urandom_range(0, 16'hFFFF));
            n_cfg += 5;
            for (int k = 0; k < N_RANDOM / 4; k++) begin
                if (ph == 1 && k == 10) hold_off = 1'b1;
                if (k % 5 == 0)
                    send_sample($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                                $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                                $urandom_range(0, 1));
                else
                    send_sample(16'($urandom), 16'($urandom), $urandom_range(0, 1));
            end
            drain();
        end

        $display("covered %0d samples over %0d register writes, extremes and random settings",
                 n_sent, n_cfg);
        $display("receiver long hold-off and random gaps on both channels exercised");
        if (n_err == 0 && locked_q.size() == 0) begin
            $display("PASS sam_pll_carrier_dc_removal");
        end else begin
            $display("FAIL sam_pll_carrier_dc_removal");
        end
        $finish;
    end

    // safety net against a hung handshake
    initial begin
        #(64'd40_000_000);
        $display("FAIL sam_pll_carrier_dc_removal");
        $finish;
    end

endmodule

### filelist.f
rtl/samdc_pkg.sv
rtl/samdc_cordic.sv
rtl/sam_pll_carrier_dc_removal.sv
sim/sam_pll_carrier_dc_removal_tb.sv
